### hw/rtl/battery_dispatch_lookahead_top_assert.svh
// Assertion macros for the battery dispatch block checker.
`ifndef BATTERY_DISPATCH_LOOKAHEAD_TOP_ASSERT_SVH
`define BATTERY_DISPATCH_LOOKAHEAD_TOP_ASSERT_SVH

// Same-cycle implication, sampled on aclk, off during reset.
`define BDL_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk, off during reset.
`define BDL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/bdl_pkg.sv
// Shared constants for the battery dispatch lookahead block.
package bdl_pkg;

    localparam int BDL_HORIZON = 256;

    localparam int SOC_BAND   = 512;
    localparam int CHARGE_CAP = 153600;

    localparam int POS_W   = 8;
    localparam int PWR_W   = 24;
    localparam int SOC_W   = 17;
    localparam int WIN_W   = 9;
    localparam int RAMP_W  = 23;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 24;

    // forecast word: {grid, source, load}
    localparam int MEM_W  = 2 * PWR_W + 1;
    localparam int PROD_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_PREP_WINDOW  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RAMP_LIMIT   = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RAMP_EVENT   = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BATT_MIN     = 8'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BATT_MAX     = 8'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SOC_MIN      = 8'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SOC_MAX      = 8'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SOC_TARGET   = 8'd7;

    localparam logic [WIN_W-1:0]        RST_PREP_WINDOW = 9'd10;
    localparam logic [RAMP_W-1:0]       RST_RAMP_LIMIT  = 23'd10240;
    localparam logic [RAMP_W-1:0]       RST_RAMP_EVENT  = 23'd20480;
    localparam logic signed [PWR_W-1:0] RST_BATT_MIN    = -24'sd102400;
    localparam logic [RAMP_W-1:0]       RST_BATT_MAX    = 23'd102400;
    localparam logic [SOC_W-1:0]        RST_SOC_MIN     = 17'd20480;
    localparam logic [SOC_W-1:0]        RST_SOC_MAX     = 17'd92160;
    localparam logic [SOC_W-1:0]        RST_SOC_TARGET  = 17'd81920;

endpackage

### hw/rtl/bdl_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bdl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                             clk,
    input  logic                             we,
    input  logic [$clog2(DEPTH)-1:0]         waddr,
    input  logic [WIDTH-1:0]                 wdata,
    input  logic                             re,
    input  logic [$clog2(DEPTH)-1:0]         raddr,
    output logic [WIDTH-1:0]                 rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

### hw/rtl/battery_dispatch_lookahead_top.sv
// Battery dispatch with forecast lookahead: top level.
//
// Load items write one forecast slot into a single RAM and return a zero result once the
// output register is free. A step item reads its own slot and streams the window of up
// to prep_window slots that starts there through the RAM read port, one slot per cycle,
// stopping at the first outage or shortfall; when a pre-charge ramp is due, a bit-serial
// divide of the 32-bit product by prep_window follows the scan. One item is in work
// at a time; a finished result waits in the output register while the next item is
// taken. Forecast slots hold no reset value and must be written before they are read.
module battery_dispatch_lookahead_top
    import bdl_pkg::*;
#(
    parameter int HORIZON = BDL_HORIZON
) (
    input  logic                         aclk,
    input  logic                         aresetn,

    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [CFG_IDX_W-1:0]         cfg_index,
    input  logic [CFG_DATA_W-1:0]        cfg_data,

    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic                         s_func,
    input  logic [POS_W-1:0]             s_position,
    input  logic signed [PWR_W-1:0]      s_load_power,
    input  logic signed [PWR_W-1:0]      s_source_limit,
    input  logic                         s_grid_up,
    input  logic [SOC_W-1:0]             s_charge_state,
    input  logic signed [PWR_W-1:0]      s_prev_ref,
    input  logic [WIN_W-1:0]             s_series_len,

    output logic                         m_valid,
    input  logic                         m_ready,
    output logic signed [PWR_W-1:0]      m_ref_power,
    output logic                         m_event_mode,
    output logic                         m_is_step
);

    localparam int AW = $clog2(HORIZON);
    localparam int CW = $clog2(PROD_W);
    localparam logic [AW-1:0] LAST_SLOT = AW'(HORIZON - 1);
    localparam logic signed [25:0] CAP26 = 26'(CHARGE_CAP);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SCAN = 3'd1;
    localparam logic [2:0] ST_EVAL = 3'd2;
    localparam logic [2:0] ST_MUL  = 3'd3;
    localparam logic [2:0] ST_DIV  = 3'd4;
    localparam logic [2:0] ST_BASE = 3'd5;
    localparam logic [2:0] ST_LIM  = 3'd6;
    localparam logic [2:0] ST_DONE = 3'd7;

    function automatic logic [AW-1:0] slot_of(input logic [POS_W-1:0] v);
        int unsigned r;
        r = 32'(v);
        for (int j = 7; j >= 0; j--) begin
            if (r >= (HORIZON << j)) begin
                r = r - (HORIZON << j);
            end
        end
        return r[AW-1:0];
    endfunction

    // configuration
    logic [WIN_W-1:0]        pw_reg;
    logic [RAMP_W-1:0]       rl_reg;
    logic [RAMP_W-1:0]       rle_reg;
    logic signed [PWR_W-1:0] bmin_reg;
    logic [RAMP_W-1:0]       bmax_reg;
    logic [SOC_W-1:0]        socmin_reg;
    logic [SOC_W-1:0]        socmax_reg;
    logic [SOC_W-1:0]        soctgt_reg;

    logic [2:0] state_reg, state_next;

    logic [SOC_W-1:0]        soc_reg;
    logic signed [PWR_W-1:0] prev_reg;
    logic [AW-1:0]           addr_reg;
    logic [WIN_W-1:0]        left_reg;
    logic [WIN_W-1:0]        off_reg;
    logic [WIN_W-1:0]        doff_reg;
    logic                    first_reg;
    logic                    dv_reg;
    logic                    dfirst_reg;
    logic                    dscan_reg;
    logic                    kk_have_reg;
    logic                    hit_reg;
    logic [WIN_W-1:0]        dist_reg;
    logic signed [24:0]      target_reg;
    logic signed [PWR_W-1:0] kk_load_reg;
    logic signed [PWR_W-1:0] kk_src_reg;
    logic                    kk_grid_reg;
    logic                    ev_reg;
    logic [PROD_W-1:0]       quo_reg;
    logic [WIN_W-1:0]        rem_reg;
    logic [CW-1:0]           dcnt_reg;
    logic signed [25:0]      ref_reg;

    logic                    m_valid_reg;
    logic signed [PWR_W-1:0] res_ref_reg;
    logic                    res_ev_reg;
    logic                    res_step_reg;
    logic signed [PWR_W-1:0] out_ref_reg;
    logic                    out_ev_reg;
    logic                    out_step_reg;

    logic                    accept;
    logic [WIN_W-1:0]        win;
    logic [WIN_W-1:0]        avail;
    logic [WIN_W-1:0]        cnt;
    logic                    issue;
    logic                    kk_ok;
    logic [MEM_W-1:0]        rdata;
    logic signed [PWR_W-1:0] d_load;
    logic signed [PWR_W-1:0] d_src;
    logic                    d_grid;
    logic                    d_evt;
    logic                    hit_now;
    logic signed [24:0]      d_target;
    logic                    scan_end;
    logic signed [24:0]      bmax25;
    logic                    kk_evt;
    logic                    ev_w;
    logic [9:0]              numer;
    logic [PROD_W-1:0]       prod_w;
    logic [WIN_W:0]          rem_sh;
    logic signed [25:0]      base_w;
    logic signed [25:0]      lim_w;

    assign accept    = s_valid && s_ready;
    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;

    assign m_valid      = m_valid_reg;
    assign m_ref_power  = out_ref_reg;
    assign m_event_mode = out_ev_reg;
    assign m_is_step    = out_step_reg;

    bdl_ram #(
        .WIDTH (MEM_W),
        .DEPTH (HORIZON)
    ) u_fcst (
        .clk   (aclk),
        .we    (accept && !s_func),
        .waddr (slot_of(s_position)),
        .wdata ({s_grid_up, s_source_limit, s_load_power}),
        .re    (issue),
        .raddr (addr_reg),
        .rdata (rdata)
    );

    // scan length: min(window, series_len - k), zero past the series
    always_comb begin
        win   = (pw_reg > 9'd1) ? pw_reg : 9'd1;
        avail = s_series_len - {1'b0, s_position};
        if (s_series_len > {1'b0, s_position}) begin
            cnt = (avail < win) ? avail : win;
        end else begin
            cnt = '0;
        end
    end

    assign issue    = (state_reg == ST_SCAN) && (first_reg || (left_reg != '0));
    assign d_load   = rdata[PWR_W-1:0];
    assign d_src    = rdata[2*PWR_W-1:PWR_W];
    assign d_grid   = rdata[MEM_W-1];
    assign d_evt    = !d_grid || (d_load > d_src);
    assign hit_now  = dv_reg && dscan_reg && !hit_reg && d_evt;
    assign kk_ok    = kk_have_reg || (dv_reg && dfirst_reg);
    assign scan_end = kk_ok && (hit_now || hit_reg || !issue);
    assign bmax25   = $signed({2'b00, bmax_reg});

    always_comb begin
        logic signed [24:0] diff;
        diff = 25'(d_load) - 25'(d_src);
        if (!d_grid) begin
            d_target = (25'(d_load) < bmax25) ? 25'(d_load) : bmax25;
        end else begin
            d_target = (diff < bmax25) ? diff : bmax25;
        end
    end

    assign kk_evt = !kk_grid_reg || (kk_load_reg > kk_src_reg);
    assign ev_w   = hit_reg && (target_reg > 25'sd0);
    assign numer  = {1'b0, pw_reg} - {1'b0, dist_reg} + 10'd1;
    assign prod_w = {9'd0, target_reg[RAMP_W-1:0]} * {23'd0, numer[WIN_W-1:0]};
    assign rem_sh = {rem_reg, quo_reg[PROD_W-1]};

    always_comb begin
        logic signed [25:0] kl;
        logic signed [25:0] ks;
        logic signed [25:0] cap;
        logic signed [25:0] spare;
        logic signed [25:0] r;
        logic signed [25:0] bmin26;
        logic signed [18:0] soc_s;
        logic signed [18:0] lim_soc;
        kl      = 26'(kk_load_reg);
        ks      = 26'(kk_src_reg);
        bmin26  = 26'(bmin_reg);
        cap     = -bmin26;
        if (cap > CAP26) begin
            cap = CAP26;
        end
        spare   = ks - kl;
        soc_s   = $signed({2'b00, soc_reg});
        lim_soc = $signed({2'b00, soctgt_reg}) - 19'(SOC_BAND);
        if (!kk_grid_reg) begin
            r = kl;
        end else if (kl > ks) begin
            r = kl - ks;
        end else if ((soc_s < lim_soc) && (spare > 26'sd0)) begin
            r = (spare < cap) ? -spare : -cap;
        end else begin
            r = '0;
        end
        if ((soc_reg <= socmin_reg) && (r > 26'sd0)) begin
            r = '0;
        end
        if ((soc_reg >= socmax_reg) && (r < 26'sd0)) begin
            r = '0;
        end
        if (r > $signed({3'b000, bmax_reg})) begin
            r = $signed({3'b000, bmax_reg});
        end
        if (r < bmin26) begin
            r = bmin26;
        end
        base_w = r;
    end

    always_comb begin
        logic signed [25:0] du;
        logic signed [25:0] hi;
        logic signed [25:0] lo;
        logic signed [25:0] r;
        du = ev_reg ? $signed({3'b000, rle_reg}) : $signed({3'b000, rl_reg});
        hi = 26'(prev_reg) + du;
        lo = 26'(prev_reg) - du;
        r  = ref_reg;
        if (r > hi) begin
            r = hi;
        end
        if (r < lo) begin
            r = lo;
        end
        if ((soc_reg <= socmin_reg) && (r > 26'sd0)) begin
            r = '0;
        end
        if ((soc_reg >= socmax_reg) && (r < 26'sd0)) begin
            r = '0;
        end
        if (!kk_grid_reg && (r < 26'sd0)) begin
            r = '0;
        end
        if (r < 26'(bmin_reg)) begin
            r = 26'(bmin_reg);
        end
        if (r > $signed({3'b000, bmax_reg})) begin
            r = $signed({3'b000, bmax_reg});
        end
        lim_w = r;
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = s_func ? ST_SCAN : ST_DONE;
                end
            end
            ST_SCAN: begin
                if (scan_end) begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL: state_next = (ev_w && !kk_evt) ? ST_MUL : ST_BASE;
            ST_MUL:  state_next = ST_DIV;
            ST_DIV: begin
                if (dcnt_reg == CW'(PROD_W - 1)) begin
                    state_next = ST_LIM;
                end
            end
            ST_BASE: state_next = ST_LIM;
            ST_LIM:  state_next = ST_DONE;
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            first_reg   <= 1'b0;
            left_reg    <= '0;
            dv_reg      <= 1'b0;
            kk_have_reg <= 1'b0;
            hit_reg     <= 1'b0;
            pw_reg      <= RST_PREP_WINDOW;
            rl_reg      <= RST_RAMP_LIMIT;
            rle_reg     <= RST_RAMP_EVENT;
            bmin_reg    <= RST_BATT_MIN;
            bmax_reg    <= RST_BATT_MAX;
            socmin_reg  <= RST_SOC_MIN;
            socmax_reg  <= RST_SOC_MAX;
            soctgt_reg  <= RST_SOC_TARGET;
        end else begin
            state_reg <= state_next;

            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_PREP_WINDOW: pw_reg     <= cfg_data[WIN_W-1:0];
                    REG_RAMP_LIMIT:  rl_reg     <= cfg_data[RAMP_W-1:0];
                    REG_RAMP_EVENT:  rle_reg    <= cfg_data[RAMP_W-1:0];
                    REG_BATT_MIN:    bmin_reg   <= $signed(cfg_data[PWR_W-1:0]);
                    REG_BATT_MAX:    bmax_reg   <= cfg_data[RAMP_W-1:0];
                    REG_SOC_MIN:     socmin_reg <= cfg_data[SOC_W-1:0];
                    REG_SOC_MAX:     socmax_reg <= cfg_data[SOC_W-1:0];
                    REG_SOC_TARGET:  soctgt_reg <= cfg_data[SOC_W-1:0];
                    default: ;
                endcase
            end

            if (accept) begin
                soc_reg      <= s_charge_state;
                prev_reg     <= s_prev_ref;
                addr_reg     <= slot_of(s_position);
                left_reg     <= cnt;
                off_reg      <= '0;
                first_reg    <= s_func;
                kk_have_reg  <= 1'b0;
                hit_reg      <= 1'b0;
                res_ref_reg  <= '0;
                res_ev_reg   <= 1'b0;
                res_step_reg <= s_func;
            end

            dv_reg <= issue;
            if (issue) begin
                first_reg  <= 1'b0;
                dfirst_reg <= first_reg;
                dscan_reg  <= (left_reg != '0);
                doff_reg   <= off_reg;
                off_reg    <= off_reg + 9'd1;
                if (left_reg != '0) begin
                    left_reg <= left_reg - 9'd1;
                end
                addr_reg <= (addr_reg == LAST_SLOT) ? '0 : addr_reg + AW'(1);
            end

            if ((state_reg == ST_SCAN) && dv_reg && dfirst_reg) begin
                kk_have_reg <= 1'b1;
                kk_load_reg <= d_load;
                kk_src_reg  <= d_src;
                kk_grid_reg <= d_grid;
            end
            if ((state_reg == ST_SCAN) && hit_now) begin
                hit_reg    <= 1'b1;
                dist_reg   <= doff_reg;
                target_reg <= d_target;
            end

            if (state_reg == ST_EVAL) begin
                ev_reg <= ev_w;
            end
            if (state_reg == ST_MUL) begin
                quo_reg  <= prod_w;
                rem_reg  <= '0;
                dcnt_reg <= '0;
            end
            if (state_reg == ST_DIV) begin
                dcnt_reg <= dcnt_reg + CW'(1);
                if (rem_sh >= {1'b0, pw_reg}) begin
                    rem_reg <= WIN_W'(rem_sh - {1'b0, pw_reg});
                    quo_reg <= {quo_reg[PROD_W-2:0], 1'b1};
                end else begin
                    rem_reg <= rem_sh[WIN_W-1:0];
                    quo_reg <= {quo_reg[PROD_W-2:0], 1'b0};
                end
                if (dcnt_reg == CW'(PROD_W - 1)) begin
                    ref_reg <= '0;
                end
            end
            if ((state_reg == ST_DIV) && (dcnt_reg == CW'(PROD_W - 1))) begin
                if (rem_sh >= {1'b0, pw_reg}) begin
                    ref_reg <= $signed({1'b0, quo_reg[PWR_W-1:0], 1'b1});
                end else begin
                    ref_reg <= $signed({1'b0, quo_reg[PWR_W-1:0], 1'b0});
                end
            end
            if (state_reg == ST_BASE) begin
                ref_reg <= base_w;
            end
            if (state_reg == ST_LIM) begin
                res_ref_reg <= lim_w[PWR_W-1:0];
                res_ev_reg  <= ev_reg;
            end

            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if ((state_reg == ST_DONE) && (!m_valid_reg || m_ready)) begin
                m_valid_reg  <= 1'b1;
                out_ref_reg  <= res_ref_reg;
                out_ev_reg   <= res_ev_reg;
                out_step_reg <= res_step_reg;
            end
        end
    end

endmodule

### hw/rtl/bdl_checker.sv
// Port-level checker for the battery dispatch block, with its bind.
`include "battery_dispatch_lookahead_top_assert.svh"

module bdl_checker
    import bdl_pkg::*;
(
    input logic                    aclk,
    input logic                    aresetn,
    input logic                    s_valid,
    input logic                    s_ready,
    input logic                    m_valid,
    input logic                    m_ready,
    input logic signed [PWR_W-1:0] m_ref_power,
    input logic                    m_event_mode,
    input logic                    m_is_step
);

    `BDL_ASSERT_NOW(a_load_zero, m_valid && !m_is_step, (m_ref_power == '0) && !m_event_mode, "load item result not zero")
    `BDL_ASSERT_NOW(a_event_step, m_valid && m_event_mode, m_is_step, "event flag on load item")
    `BDL_ASSERT_NEXT(a_one_item, s_valid && s_ready, !s_ready, "second item taken while busy")
    `BDL_ASSERT_NEXT(a_hold, m_valid && !m_ready, m_valid && $stable(m_ref_power) && $stable(m_is_step), "stalled result changed")

endmodule

bind battery_dispatch_lookahead_top bdl_checker u_bdl_checker (.*);

### tb/sv/battery_dispatch_lookahead_top_test.sv
// Self-checking testbench for battery_dispatch_lookahead_top with a built-in dispatch predictor.
`timescale 1ns / 100ps

module battery_dispatch_lookahead_top_test;
    import bdl_pkg::*;

    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_STEP = 1'b1;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 8'd200;
    localparam int PHASE_ITEMS = 280;
    localparam int MAX_REPORTS = 40;

    typedef struct {
        logic                    func;
        logic [POS_W-1:0]        position;
        logic signed [PWR_W-1:0] load_power;
        logic signed [PWR_W-1:0] source_limit;
        logic                    grid_up;
        logic [SOC_W-1:0]        charge_state;
        logic signed [PWR_W-1:0] prev_ref;
        logic [WIN_W-1:0]        series_len;
    } dispatch_item_t;

    typedef struct {
        logic signed [PWR_W-1:0] ref_power;
        logic                    event_mode;
        logic                    is_step;
    } dispatch_result_t;

    logic                    aclk;
    logic                    aresetn;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [CFG_IDX_W-1:0]    cfg_index;
    logic [CFG_DATA_W-1:0]   cfg_data;
    logic                    s_valid;
    logic                    s_ready;
    logic                    s_func;
    logic [POS_W-1:0]        s_position;
    logic signed [PWR_W-1:0] s_load_power;
    logic signed [PWR_W-1:0] s_source_limit;
    logic                    s_grid_up;
    logic [SOC_W-1:0]        s_charge_state;
    logic signed [PWR_W-1:0] s_prev_ref;
    logic [WIN_W-1:0]        s_series_len;
    logic                    m_valid;
    logic                    m_ready;
    logic signed [PWR_W-1:0] m_ref_power;
    logic                    m_event_mode;
    logic                    m_is_step;

    // register copies used by the predictor
    logic [WIN_W-1:0]        cfg_prep_window = RST_PREP_WINDOW;
    logic [RAMP_W-1:0]       cfg_ramp_limit  = RST_RAMP_LIMIT;
    logic [RAMP_W-1:0]       cfg_ramp_event  = RST_RAMP_EVENT;
    logic signed [PWR_W-1:0] cfg_batt_min    = RST_BATT_MIN;
    logic [RAMP_W-1:0]       cfg_batt_max    = RST_BATT_MAX;
    logic [SOC_W-1:0]        cfg_soc_min     = RST_SOC_MIN;
    logic [SOC_W-1:0]        cfg_soc_max     = RST_SOC_MAX;
    logic [SOC_W-1:0]        cfg_soc_target  = RST_SOC_TARGET;

    logic signed [PWR_W-1:0] fc_load   [BDL_HORIZON];
    logic signed [PWR_W-1:0] fc_source [BDL_HORIZON];
    logic                    fc_grid   [BDL_HORIZON];
    bit                      slot_filled [BDL_HORIZON];

    dispatch_item_t   pending_items[$];
    dispatch_result_t expected_results[$];
    int mismatch_count = 0;
    int source_gap_pct = 0;
    int sink_stall_pct = 0;

    battery_dispatch_lookahead_top uut (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_func(s_func),
        .s_position(s_position),
        .s_load_power(s_load_power),
        .s_source_limit(s_source_limit),
        .s_grid_up(s_grid_up),
        .s_charge_state(s_charge_state),
        .s_prev_ref(s_prev_ref),
        .s_series_len(s_series_len),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_ref_power(m_ref_power),
        .m_event_mode(m_event_mode),
        .m_is_step(m_is_step)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #100_000_000;
        $display("== FAIL ==");
        $finish;
    end

    function automatic longint min_l(longint a, longint b);
        return (a < b) ? a : b;
    endfunction

    function automatic longint max_l(longint a, longint b);
        return (a > b) ? a : b;
    endfunction

    function automatic longint base_reference(longint ld, longint src, logic grid, longint soc);
        longint bmin = cfg_batt_min;
        longint bmax = cfg_batt_max;
        longint smin = cfg_soc_min;
        longint smax = cfg_soc_max;
        longint starget = cfg_soc_target;
        longint pw;
        if (!grid) begin
            pw = ld;
        end else if (ld > src) begin
            pw = ld - src;
        end else if (soc < starget - SOC_BAND && src - ld > 0) begin
            pw = -min_l(src - ld, min_l(-bmin, CHARGE_CAP));
        end else begin
            pw = 0;
        end
        if (soc <= smin && pw > 0) pw = 0;
        if (soc >= smax && pw < 0) pw = 0;
        pw = min_l(pw, bmax);
        return max_l(pw, bmin);
    endfunction

    function automatic dispatch_result_t predict_dispatch(dispatch_item_t it);
        dispatch_result_t res;
        longint bmin = cfg_batt_min;
        longint bmax = cfg_batt_max;
        longint smin = cfg_soc_min;
        longint smax = cfg_soc_max;
        longint pwin = cfg_prep_window;
        longint k = it.position;
        longint soc = it.charge_state;
        longint prev = it.prev_ref;
        longint n = it.series_len;
        longint last, hit, tgt, pw, du, ld, src, ahead, i;
        logic ev;
        logic grid_k;
        int s;
        res.ref_power = '0;
        res.event_mode = 1'b0;
        res.is_step = 1'b0;
        if (it.func == FUNC_LOAD) begin
            fc_load[it.position] = it.load_power;
            fc_source[it.position] = it.source_limit;
            fc_grid[it.position] = it.grid_up;
            return res;
        end
        // first outage or shortfall within the window
        last = min_l(k + max_l(pwin, 1) - 1, n - 1);
        hit = -1;
        tgt = 0;
        for (i = k; i <= last && hit < 0; i++) begin
            s = int'(i % BDL_HORIZON);
            ld = fc_load[s];
            src = fc_source[s];
            if (!fc_grid[s]) begin
                tgt = min_l(ld, bmax);
                hit = i;
            end else if (ld > src) begin
                tgt = min_l(max_l(ld - src, 0), bmax);
                hit = i;
            end
        end
        ld = fc_load[it.position];
        src = fc_source[it.position];
        grid_k = fc_grid[it.position];
        ev = (hit >= 0 && tgt > 0);
        if (ev && grid_k && ld <= src) begin
            // event strictly ahead: pre-charge ramp
            ahead = hit - k;
            pw = 0;
            if (ahead <= pwin && pwin > 0) pw = tgt * (pwin - ahead + 1) / pwin;
            pw = max_l(pw, 0);
        end else begin
            pw = base_reference(ld, src, grid_k, soc);
        end
        du = ev ? longint'(cfg_ramp_event) : longint'(cfg_ramp_limit);
        pw = min_l(pw, prev + du);
        pw = max_l(pw, prev - du);
        if (soc <= smin && pw > 0) pw = 0;
        if (soc >= smax && pw < 0) pw = 0;
        if (!grid_k && pw < 0) pw = 0;
        pw = min_l(max_l(pw, bmin), bmax);
        res.ref_power = pw[PWR_W-1:0];
        res.event_mode = ev;
        res.is_step = 1'b1;
        return res;
    endfunction

    task automatic report_mismatch(string msg);
        if (mismatch_count < MAX_REPORTS) $display("MISMATCH at %0t: %s", $time, msg);
        mismatch_count++;
    endtask

    // driver
    always @(posedge aclk) begin
        dispatch_item_t cur;
        if (!aresetn) begin
            s_valid <= 1'b0;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= sink_stall_pct);
            if (!s_valid || s_ready) begin
                if (pending_items.size() > 0 && $urandom_range(0, 99) >= source_gap_pct) begin
                    cur = pending_items.pop_front();
                    s_func         <= cur.func;
                    s_position     <= cur.position;
                    s_load_power   <= cur.load_power;
                    s_source_limit <= cur.source_limit;
                    s_grid_up      <= cur.grid_up;
                    s_charge_state <= cur.charge_state;
                    s_prev_ref     <= cur.prev_ref;
                    s_series_len   <= cur.series_len;
                    s_valid        <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: results are checked before the item taken on the same edge is predicted
    always @(posedge aclk) begin
        dispatch_item_t seen;
        dispatch_result_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch($sformatf("unexpected result ref %0d ev %0b step %0b",
                                              m_ref_power, m_event_mode, m_is_step));
                end else begin
                    want = expected_results.pop_front();
                    if (m_ref_power !== want.ref_power || m_event_mode !== want.event_mode ||
                        m_is_step !== want.is_step)
                        report_mismatch($sformatf(
                            "ref %0d ev %0b step %0b, expected ref %0d ev %0b step %0b",
                            m_ref_power, m_event_mode, m_is_step,
                            want.ref_power, want.event_mode, want.is_step));
                end
            end
            if (s_valid && s_ready) begin
                seen.func         = s_func;
                seen.position     = s_position;
                seen.load_power   = s_load_power;
                seen.source_limit = s_source_limit;
                seen.grid_up      = s_grid_up;
                seen.charge_state = s_charge_state;
                seen.prev_ref     = s_prev_ref;
                seen.series_len   = s_series_len;
                expected_results.push_back(predict_dispatch(seen));
            end
        end
    end

    function automatic logic signed [PWR_W-1:0] pick_power();
        case ($urandom_range(0, 11))
            0: return 24'sh800000;
            1: return 24'sh7FFFFF;
            2: return '0;
            3, 4: return $urandom;
            default: return $urandom_range(0, 300000) - 150000;
        endcase
    endfunction

    function automatic logic [SOC_W-1:0] pick_soc();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return 17'd102400;
            2: return 17'd131071;
            3: return cfg_soc_min;
            4: return cfg_soc_max;
            5: return cfg_soc_target - SOC_BAND;
            6: return cfg_soc_target - SOC_BAND - 1;
            default: return $urandom_range(0, 102400);
        endcase
    endfunction

    function automatic dispatch_item_t random_item();
        dispatch_item_t it;
        it.func         = FUNC_LOAD;
        it.position     = $urandom;
        it.load_power   = pick_power();
        it.source_limit = pick_power();
        it.grid_up      = ($urandom_range(0, 9) != 0);
        it.charge_state = pick_soc();
        it.prev_ref     = pick_power();
        it.series_len   = $urandom;
        return it;
    endfunction

    // true when every slot a step may read has been written
    function automatic bit scan_filled(int k, int n);
        int last;
        last = k + ((cfg_prep_window > 1) ? int'(cfg_prep_window) : 1) - 1;
        if (last > n - 1) last = n - 1;
        for (int i = k; i <= last; i++)
            if (!slot_filled[i % BDL_HORIZON]) return 1'b0;
        return 1'b1;
    endfunction

    function automatic void push_item(dispatch_item_t it);
        if (it.func == FUNC_LOAD) slot_filled[it.position] = 1'b1;
        pending_items.push_back(it);
    endfunction

    function automatic void add_item(logic func, int pos, int ld, int src, logic grid,
                                     int soc, int prev, int n);
        dispatch_item_t it;
        it.func         = func;
        it.position     = pos;
        it.load_power   = ld;
        it.source_limit = src;
        it.grid_up      = grid;
        it.charge_state = soc;
        it.prev_ref     = prev;
        it.series_len   = n;
        push_item(it);
    endfunction

    function automatic void queue_slot(int s);
        dispatch_item_t it;
        it = random_item();
        it.position = s;
        if ($urandom_range(0, 3) != 0) begin
            it.load_power = $urandom_range(0, 120000);
            if ($urandom_range(0, 4) == 0)
                it.source_limit = it.load_power - $urandom_range(1, 60000);
            else
                it.source_limit = it.load_power + $urandom_range(0, 90000);
        end
        push_item(it);
    endfunction

    function automatic void queue_step(int k);
        dispatch_item_t it;
        int tries;
        if (!slot_filled[k]) begin
            queue_slot(k);
            return;
        end
        it = random_item();
        it.func = FUNC_STEP;
        it.position = k;
        tries = 0;
        while (tries < 4 && !scan_filled(k, it.series_len)) begin
            case ($urandom_range(0, 3))
                0: it.series_len = k + $urandom_range(1, 24);
                1: it.series_len = $urandom_range(0, 511);
                default: it.series_len = k + $urandom_range(1, 4);
            endcase
            tries++;
        end
        if (!scan_filled(k, it.series_len)) it.series_len = k;
        push_item(it);
    endfunction

    task automatic wait_drained();
        while (pending_items.size() != 0 || s_valid || expected_results.size() != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, longint value);
        cfg_index <= idx;
        cfg_data  <= value[CFG_DATA_W-1:0];
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_PREP_WINDOW: cfg_prep_window = value[WIN_W-1:0];
            REG_RAMP_LIMIT:  cfg_ramp_limit  = value[RAMP_W-1:0];
            REG_RAMP_EVENT:  cfg_ramp_event  = value[RAMP_W-1:0];
            REG_BATT_MIN:    cfg_batt_min    = value[PWR_W-1:0];
            REG_BATT_MAX:    cfg_batt_max    = value[RAMP_W-1:0];
            REG_SOC_MIN:     cfg_soc_min     = value[SOC_W-1:0];
            REG_SOC_MAX:     cfg_soc_max     = value[SOC_W-1:0];
            REG_SOC_TARGET:  cfg_soc_target  = value[SOC_W-1:0];
            default: ;
        endcase
        @(posedge aclk);
    endtask

    task automatic configure(longint win, longint ramp, longint ramp_ev, longint bmin,
                             longint bmax, longint smin, longint smax, longint starget);
        write_reg(REG_PREP_WINDOW, win);
        write_reg(REG_RAMP_LIMIT, ramp);
        write_reg(REG_RAMP_EVENT, ramp_ev);
        write_reg(REG_BATT_MIN, bmin);
        write_reg(REG_BATT_MAX, bmax);
        write_reg(REG_SOC_MIN, smin);
        write_reg(REG_SOC_MAX, smax);
        write_reg(REG_SOC_TARGET, starget);
    endtask

    // mostly runs of written slots followed by steps inside them, plus stray items
    task automatic run_phase(int src_gap, int sink_stall, int n_items);
        int queued, base, run_len;
        source_gap_pct = src_gap;
        sink_stall_pct = sink_stall;
        queued = 0;
        while (queued < n_items) begin
            if ($urandom_range(0, 9) < 8) begin
                base = $urandom_range(0, 255);
                run_len = ($urandom_range(0, 39) == 0) ? $urandom_range(20, 260)
                                                       : $urandom_range(1, 16);
                for (int j = 0; j < run_len; j++) queue_slot((base + j) % BDL_HORIZON);
                queued += run_len;
                repeat ($urandom_range(1, 10)) begin
                    queue_step((base + $urandom_range(0, run_len - 1)) % BDL_HORIZON);
                    queued++;
                end
            end else begin
                if ($urandom_range(0, 2) == 0) queue_slot($urandom_range(0, 255));
                else queue_step($urandom_range(0, 255));
                queued++;
            end
        end
        wait_drained();
    endtask

    initial begin
        aresetn        = 1'b0;
        cfg_valid      = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        s_valid        = 1'b0;
        s_func         = FUNC_LOAD;
        s_position     = '0;
        s_load_power   = '0;
        s_source_limit = '0;
        s_grid_up      = 1'b0;
        s_charge_state = '0;
        s_prev_ref     = '0;
        s_series_len   = '0;
        m_ready        = 1'b0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed items on reset register values
        source_gap_pct = 7;
        sink_stall_pct = 59;
        add_item(FUNC_LOAD, 0, 50000, 80000, 1'b1, 131071, -1, 511);
        add_item(FUNC_LOAD, 1, 60000, 40000, 1'b1, 131071, -1, 511);
        add_item(FUNC_LOAD, 2, 8388607, -8388608, 1'b1, 0, 0, 0);
        add_item(FUNC_LOAD, 3, -8388608, 8388607, 1'b0, 0, 0, 0);
        add_item(FUNC_LOAD, 4, 0, 0, 1'b1, 0, 0, 0);
        add_item(FUNC_LOAD, 5, 30000, 200000, 1'b1, 0, 0, 0);
        add_item(FUNC_LOAD, 6, 10000, 20000, 1'b1, 0, 0, 0);
        add_item(FUNC_LOAD, 7, 10000, 20000, 1'b1, 0, 0, 0);
        add_item(FUNC_LOAD, 8, 10000, 20000, 1'b1, 0, 0, 0);
        add_item(FUNC_LOAD, 9, 45000, 0, 1'b0, 0, 0, 0);
        add_item(FUNC_LOAD, 255, 20000, 90000, 1'b1, 0, 0, 0);
        add_item(FUNC_STEP, 0, 0, 0, 1'b0, 40000, 0, 256);
        add_item(FUNC_STEP, 1, -1, -1, 1'b1, 50000, 20000, 256);
        add_item(FUNC_STEP, 2, 0, 0, 1'b0, 102400, 8388607, 256);
        add_item(FUNC_STEP, 3, 0, 0, 1'b0, 0, -8388608, 256);
        add_item(FUNC_STEP, 4, 0, 0, 1'b0, 20480, 0, 10);
        add_item(FUNC_STEP, 5, 0, 0, 1'b0, 40000, 0, 6);
        add_item(FUNC_STEP, 6, 0, 0, 1'b0, 81408, 0, 3);
        add_item(FUNC_STEP, 7, 0, 0, 1'b0, 81407, -5000, 0);
        add_item(FUNC_STEP, 255, 0, 0, 1'b0, 60000, 0, 256);
        add_item(FUNC_STEP, 255, 0, 0, 1'b0, 60000, 100000, 300);
        add_item(FUNC_STEP, 8, 0, 0, 1'b0, 131071, 8388607, 10);
        add_item(FUNC_STEP, 9, 0, 0, 1'b0, 30000, 0, 511);
        wait_drained();

        configure(10, 10240, 20480, -102400, 102400, 20480, 92160, 81920);
        write_reg(REG_SPARE, 24'hFFFFFF);
        run_phase(7, 59, PHASE_ITEMS);

        configure(1, 0, 8388607, -8388608, 8388607, 0, 102400, 102400);
        run_phase(7, 59, PHASE_ITEMS);

        // zero window: only slot k is scanned
        configure(0, 8388607, 4096, -50000, 60000, 10240, 97280, 61440);
        run_phase(59, 7, PHASE_ITEMS);

        configure(256, 30000, 8388607, -8388608, 8388607, 0, 102400, 102400);
        run_phase(59, 7, PHASE_ITEMS);

        // values outside the documented ranges
        configure(511, 5000, 60000, 1000, 100000, 0, 131071, 131071);
        run_phase(0, 0, PHASE_ITEMS);

        configure($urandom_range(2, 40), $urandom_range(0, 8388607), $urandom_range(0, 8388607),
                  -longint'($urandom_range(0, 8388608)), $urandom_range(0, 8388607),
                  $urandom_range(0, 40960), $urandom_range(61440, 102400),
                  $urandom_range(0, 102400));
        run_phase(0, 0, PHASE_ITEMS);

        repeat (600) @(posedge aclk);
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
